@@ src/rns_pkg.sv @@
// Shared types and constants of the recurrent network step block.
// Holds the request codes, the MAC command struct and the logistic table.
// No dependencies; rns_mac and recurrent_net_step_top import it.
`default_nettype none

package rns_pkg;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_STEP  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

  localparam int WEIGHT_W  = 16;
  localparam int ACT_W     = 13;
  localparam int OPND_W    = 17;
  localparam int PROD_W    = WEIGHT_W + OPND_W;
  localparam int FRAC_BITS = 12;
  // At most 24 products of magnitude 2^30 each, plus sign.
  localparam int ACC_W     = 36;

  localparam int SENSE_FIELDS = 4;
  localparam int MOTOR_FIELDS = 2;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_cmd_t;

  typedef logic [255:0][ACT_W-1:0] logistic_rom_t;

  localparam longint unsigned ONE_Q32      = 64'd4294967296;
  localparam longint unsigned EXP_32TH_Q32 = 64'd4431304193;
  localparam longint unsigned EXP_16TH_Q32 = 64'd4571968888;

  // Entry k is round(4096 * L(x)) at the middle of its interval, built from
  // Q.32 exponentials that step by exp(1/16); the lower half mirrors the upper.
  function automatic logistic_rom_t logistic_rom();
    logistic_rom_t   rom;
    longint unsigned e;
    longint unsigned mh;
    longint unsigned ml;
    longint unsigned num;
    longint unsigned den;
    longint unsigned rem;
    logic [ACT_W-1:0] v;
    rom = '0;
    e   = EXP_32TH_Q32;
    mh  = EXP_16TH_Q32 >> 16;
    ml  = EXP_16TH_Q32 & 64'hFFFF;
    for (int k = 0; k < 128; k++) begin
      num = 64'd8192 * e + ONE_Q32 + e;
      den = 64'd2 * (ONE_Q32 + e);
      // Quotient of num by den, one bit at a time; num is below 8192 * den,
      // so the quotient fits in ACT_W bits.
      rem = num;
      v   = '0;
      for (int b = ACT_W - 1; b >= 0; b--) begin
        if (rem >= (den << b)) begin
          rem  = rem - (den << b);
          v[b] = 1'b1;
        end
      end
      rom[128 + k] = v;
      rom[127 - k] = ACT_W'(4096) - v;
      e = (e * mh + ((e * ml) >> 16)) >> 16;
    end
    return rom;
  endfunction

  localparam logistic_rom_t LOGISTIC_ROM = logistic_rom();

endpackage

`default_nettype wire

@@ src/rns_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the weight store; no dependencies.
`default_nettype none

module rns_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 40
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

@@ src/rns_mac.sv @@
// Shared multiply-accumulate unit with saturation and logistic activation.
// Depends on rns_pkg for the command struct, widths and the logistic table.
`default_nettype none

module rns_mac
  import rns_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire mac_cmd_t                   cmd,
  input  wire logic signed [OPND_W-1:0]   operand,
  input  wire logic signed [WEIGHT_W-1:0] weight,
  output logic                            done,
  output logic [ACT_W-1:0]                act
);

  localparam int SH_W = ACC_W - FRAC_BITS;
  localparam logic signed [SH_W-1:0] SAT_HI = SH_W'(32767);
  localparam logic signed [SH_W-1:0] SAT_LO = SH_W'(-32768);

  mac_cmd_t                  cmd_a_r;
  mac_cmd_t                  cmd_b_r;
  logic signed [OPND_W-1:0]  opnd_a_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      done_r;
  logic signed [SH_W-1:0]    shifted;
  logic [15:0]               sat;
  logic [7:0]                rom_idx;

  // The operand is registered so that it meets the weight read back
  // from the RAM.
  assign prod_nxt = weight * opnd_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_a_r <= '0;
      cmd_b_r <= '0;
      done_r  <= 1'b0;
    end else begin
      cmd_a_r  <= cmd;
      opnd_a_r <= operand;
      cmd_b_r  <= cmd_a_r;
      prod_r   <= prod_nxt;
      done_r   <= cmd_b_r.valid && cmd_b_r.last;
      if (cmd_b_r.valid) begin
        if (cmd_b_r.first) begin
          acc_r <= ACC_W'(prod_r);
        end else begin
          acc_r <= acc_r + ACC_W'(prod_r);
        end
      end
    end
  end

  // Arithmetic shift rounds toward minus infinity, then clamp to [-8, 8).
  assign shifted = SH_W'(acc_r >>> FRAC_BITS);

  always_comb begin
    if (shifted > SAT_HI) begin
      sat = 16'h7FFF;
    end else if (shifted < SAT_LO) begin
      sat = 16'h8000;
    end else begin
      sat = shifted[15:0];
    end
  end

  assign rom_idx = {~sat[15], sat[14:8]};
  assign act     = LOGISTIC_ROM[rom_idx];
  assign done    = done_r;

endmodule

`default_nettype wire

@@ src/recurrent_net_step_top.sv @@
// Top level of the Elman recurrent network step: sequencer, hidden state,
// weight RAM instance and output register.
// Depends on rns_pkg, rns_ram and rns_mac.
//
// Usage: one input channel (in_valid / in_stall) carries requests, one
// result channel (out_valid / out_stall) carries the two motor values.
// A weight write stores in_weight_value at in_weight_index (indexes past the
// store are dropped) and a clear zeros the hidden vector; neither stalls
// the input and neither gives a result. Request code 3 is dropped.
// A step runs every node through one shared multiply-accumulate unit, one
// product per cycle from the weight RAM, and each node then waits in the
// drain state while the MAC pipeline (operand, product and accumulator
// registers) drains. in_stall is high from the acceptance of a step until
// its result is loaded into the output register, so a step must finish
// before the next request can be accepted.
// The result waits in an output register; the next request is accepted
// while it waits, and a following step holds in its last state until the
// receiver takes the previous result.
// Reset zeros the hidden vector and drops any pending result; the weight
// store is not cleared and must be written before it is used.
`default_nettype none

module recurrent_net_step_top
  import rns_pkg::*;
#(
  parameter int INPUTS  = 4,
  parameter int HIDDEN  = 4,
  parameter int OUTPUTS = 2
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          in_req_type,
  input  wire logic [5:0]          in_weight_index,
  input  wire logic signed [15:0]  in_weight_value,
  input  wire logic signed [15:0]  in_sense_0,
  input  wire logic signed [15:0]  in_sense_1,
  input  wire logic signed [15:0]  in_sense_2,
  input  wire logic signed [15:0]  in_sense_3,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [12:0]              out_motor_0,
  output logic [12:0]              out_motor_1
);

  localparam int OFS_HO  = INPUTS * HIDDEN + HIDDEN * HIDDEN;
  localparam int WEIGHTS = OFS_HO + HIDDEN * OUTPUTS;
  localparam int NODES   = HIDDEN + OUTPUTS;
  localparam int AW      = $clog2(WEIGHTS);
  localparam int TW      = $clog2(INPUTS + HIDDEN);
  localparam int NW      = $clog2(NODES);
  localparam int HW      = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
  localparam int IW      = (INPUTS > 1) ? $clog2(INPUTS) : 1;
  localparam int SENSE_USED = (INPUTS < SENSE_FIELDS) ? INPUTS : SENSE_FIELDS;
  localparam int MOTOR_USED = (OUTPUTS < MOTOR_FIELDS) ? OUTPUTS : MOTOR_FIELDS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_FIN
  } state_t;

  state_t                             state_r;
  logic [TW-1:0]                      term_r;
  logic [NW-1:0]                      node_r;
  logic [AW-1:0]                      addr_r;
  logic [INPUTS-1:0][WEIGHT_W-1:0]    sense_r;
  logic [HIDDEN-1:0][ACT_W-1:0]       hidden_r;
  logic [HIDDEN-1:0][ACT_W-1:0]       fresh_r;
  logic [MOTOR_FIELDS-1:0][ACT_W-1:0] motor_r;
  logic [MOTOR_FIELDS-1:0][ACT_W-1:0] out_motor_r;
  logic                               out_valid_r;

  logic [SENSE_FIELDS-1:0][WEIGHT_W-1:0] sense_fields;
  logic                               in_accept;
  logic                               phase_out;
  logic [TW-1:0]                      last_term;
  logic                               is_last;
  logic [AW-1:0]                      stride;
  logic [NW-1:0]                      next_node;
  logic [AW-1:0]                      next_addr;
  logic [TW-1:0]                      hid_term;
  logic signed [OPND_W-1:0]           operand;
  logic                               ram_we;
  logic [WEIGHT_W-1:0]                ram_rdata;
  mac_cmd_t                           mac_cmd;
  logic                               mac_done;
  logic [ACT_W-1:0]                   mac_act;

  assign sense_fields = {in_sense_3, in_sense_2, in_sense_1, in_sense_0};
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign ram_we = in_accept && (in_req_type == REQ_WRITE)
                  && (int'(in_weight_index) < WEIGHTS);

  // Nodes below HIDDEN are hidden nodes, the rest are output nodes.
  assign phase_out = (int'(node_r) >= HIDDEN);
  assign last_term = phase_out ? TW'(HIDDEN - 1) : TW'(INPUTS + HIDDEN - 1);
  assign is_last   = (term_r == last_term);
  assign stride    = phase_out ? AW'(OUTPUTS) : AW'(HIDDEN);
  assign next_node = node_r + NW'(1);
  assign next_addr = (int'(next_node) < HIDDEN) ? AW'(next_node)
                                                : AW'(OFS_HO + int'(next_node) - HIDDEN);
  assign hid_term  = term_r - TW'(INPUTS);

  // Hidden-node terms walk the inputs and then the old hidden vector; output
  // terms walk the hidden vector that was just committed.
  always_comb begin
    if (phase_out) begin
      operand = {4'b0000, hidden_r[term_r[HW-1:0]]};
    end else if (int'(term_r) < INPUTS) begin
      operand = {sense_r[term_r[IW-1:0]][WEIGHT_W-1], sense_r[term_r[IW-1:0]]};
    end else begin
      operand = {4'b0000, hidden_r[hid_term[HW-1:0]]};
    end
  end

  assign mac_cmd.valid = (state_r == S_ISSUE);
  assign mac_cmd.first = (term_r == '0);
  assign mac_cmd.last  = is_last;

  rns_ram #(
    .WIDTH(WEIGHT_W),
    .DEPTH(WEIGHTS)
  ) u_weights (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_weight_index)),
    .wdata (in_weight_value),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  rns_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (mac_cmd),
    .operand (operand),
    .weight  (ram_rdata),
    .done    (mac_done),
    .act     (mac_act)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      hidden_r    <= '0;
    end else begin
      // A finished step refills the output register itself in S_FIN.
      if (out_valid_r && !out_stall && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            if (in_req_type == REQ_CLEAR) begin
              hidden_r <= '0;
            end else if (in_req_type == REQ_STEP) begin
              for (int k = 0; k < SENSE_USED; k++) begin
                sense_r[k] <= sense_fields[k];
              end
              for (int k = SENSE_USED; k < INPUTS; k++) begin
                sense_r[k] <= '0;
              end
              motor_r <= '0;
              term_r  <= '0;
              node_r  <= '0;
              addr_r  <= '0;
              state_r <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          if (is_last) begin
            state_r <= S_DRAIN;
          end else begin
            term_r <= term_r + TW'(1);
            addr_r <= addr_r + stride;
          end
        end
        S_DRAIN: begin
          if (mac_done) begin
            if (!phase_out) begin
              fresh_r[node_r[HW-1:0]] <= mac_act;
              // The last hidden node commits the whole new hidden vector.
              if (int'(node_r) == HIDDEN - 1) begin
                for (int k = 0; k < HIDDEN; k++) begin
                  hidden_r[k] <= (k == HIDDEN - 1) ? mac_act : fresh_r[k];
                end
              end
            end
            for (int m = 0; m < MOTOR_USED; m++) begin
              if (int'(node_r) == HIDDEN + m) begin
                motor_r[m] <= mac_act;
              end
            end
            if (int'(node_r) == NODES - 1) begin
              state_r <= S_FIN;
            end else begin
              node_r  <= next_node;
              term_r  <= '0;
              addr_r  <= next_addr;
              state_r <= S_ISSUE;
            end
          end
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_motor_r <= motor_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_motor_0 = out_motor_r[0];
  assign out_motor_1 = out_motor_r[1];

  // The MAC only finishes a node while the sequencer waits for it.
  a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> state_r == S_DRAIN)
    else $error("MAC finished a node outside the drain state");

  // The term counter never runs past the last term of the current node.
  a_term_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ISSUE |-> term_r <= last_term)
    else $error("term counter past the last term");

  // A finished step with a free output register presents its result next.
  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && !out_valid_r) |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished step not loaded into the output register");

  // A clear transaction leaves the hidden vector at zero.
  a_clear_zeros: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_req_type == REQ_CLEAR) |=> hidden_r == '0)
    else $error("hidden vector not zero after clear");

endmodule

`default_nettype wire
